>>> src/ppg_pkg.sv
// Shared constants, types and elaboration-time sine ROMs for the plasma pixel generator.
package ppg_pkg;

   localparam int COORD_BITS = 9;

   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 8 + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 40;

   localparam int THIRD_BITS  = COORD_BITS - 1;
   localparam int HALF_BITS   = COORD_BITS - 1;
   localparam int TERM_BITS   = ((THIRD_BITS > 8) ? THIRD_BITS : 8) + 1;
   localparam int PROD_A_BITS = COORD_BITS + 9;
   localparam int PROD_B_BITS = ((HALF_BITS + TERM_BITS) > 16) ? (HALF_BITS + TERM_BITS) : 16;

   localparam int RECIP_BITS  = 17;
   localparam int RECIP_SHIFT = 17;
   localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 17'd43691;
   localparam int RECIP_PROD_BITS = COORD_BITS + RECIP_BITS;

   localparam logic [8:0] MOD_BASE = 9'd255;

   typedef logic [255:0][7:0]  byte_rom_type;
   typedef logic [255:0][31:0] word_rom_type;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [7:0]            phase;
      logic [THIRD_BITS-1:0] y_third;
   } ppg_stage_type;

   typedef struct packed {
      logic [31:0] color;
      logic [7:0]  palette_index;
   } ppg_result_type;

   localparam longint Q_ONE     = 64'sd1073741824;
   localparam longint Q_PI      = 64'sd3373259426;
   localparam longint Q_HALF_PI = 64'sd1686629713;
   localparam longint TAYLOR_DIV [1:7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                           64'sd110, 64'sd156, 64'sd210};

   // sine of a nonnegative Q30 angle, result in [0, Q_ONE]
   function automatic longint sine_mag(input longint ax_arg);
      longint ax;
      longint x2;
      longint term;
      longint sum;
      ax = ax_arg;
      if (ax > Q_PI) ax = Q_PI;
      if (ax > Q_HALF_PI) ax = Q_PI - ax;
      x2   = (ax * ax) >> 30;
      term = ax;
      sum  = ax;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      if (sum > Q_ONE) sum = Q_ONE;
      if (ax == Q_HALF_PI) sum = Q_ONE;
      return sum;
   endfunction

   // sin(pi*k/128) in signed Q30
   function automatic longint sine_index(input logic [7:0] k);
      logic [1:0] quad;
      logic [5:0] rem;
      longint     m;
      longint     v;
      quad = k[7:6];
      rem  = k[5:0];
      if (rem == 6'd0) begin
         if (quad == 2'd1) v = Q_ONE;
         else if (quad == 2'd3) v = -Q_ONE;
         else v = 0;
      end else begin
         m = quad[0] ? (64 - longint'(rem)) : longint'(rem);
         v = sine_mag((Q_PI * m) >> 7);
         if (quad[1]) v = -v;
      end
      return v;
   endfunction

   // sin(pi*s) or sin(pi*s/2) for signed Q30 s
   function automatic longint sine_scaled(input longint s, input logic halve);
      longint as;
      longint arg;
      longint v;
      as  = (s < 0) ? -s : s;
      arg = (Q_PI * as) >> 30;
      if (halve) arg = arg >> 1;
      v = sine_mag(arg);
      return (s < 0) ? -v : v;
   endfunction

   function automatic byte_rom_type build_t1();
      byte_rom_type rom;
      longint s;
      longint as;
      longint s2;
      for (int i = 0; i < 256; i++) begin
         s  = sine_index(8'(i));
         as = (s < 0) ? -s : s;
         s2 = (as * as) >> 30;
         rom[i] = 8'((127 * Q_ONE + 127 * s2) >> 30);
      end
      return rom;
   endfunction

   function automatic byte_rom_type build_t2();
      byte_rom_type rom;
      longint s;
      longint t2;
      for (int i = 0; i < 256; i++) begin
         s  = sine_index(8'(i));
         t2 = sine_scaled(s, 1'b0);
         rom[i] = 8'((127 * Q_ONE + 127 * t2) >> 30);
      end
      return rom;
   endfunction

   function automatic word_rom_type build_palette();
      word_rom_type rom;
      longint s;
      longint u;
      longint u2;
      longint ta;
      longint a;
      longint g;
      longint b;
      for (int i = 0; i < 256; i++) begin
         s  = sine_index(8'(i));
         u  = (Q_ONE + s) >> 1;
         u2 = (u * u) >> 30;
         ta = sine_scaled(s, 1'b1);
         a  = (191 * Q_ONE + 64 * ta) >> 30;
         g  = (200 * u2) >> 30;
         b  = (200 * u) >> 30;
         rom[i] = {8'(a), 8'h00, 8'(g), 8'(b)};
      end
      return rom;
   endfunction

   localparam byte_rom_type T1_ROM  = build_t1();
   localparam byte_rom_type T2_ROM  = build_t2();
   localparam word_rom_type PAL_ROM = build_palette();

endpackage

>>> src/plasma_pixel_generator.sv
// Top level of the plasma pixel generator: stream handshake, input and result registers.
// Accepts one pixel per clock unless the receiver stalls and returns its palette index and ARGB
// color via the input and then the result register; the sustained rate is one pixel per cycle
// without back-pressure, set by a single pass through the sine ROMs, two small multipliers and
// the palette ROM between the two registers. With enable_ff low, accepted pixels produce no result.
module plasma_pixel_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_x, pixel_y, phase, zero fill
   input  logic [ppg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // palette_index, color
   output logic [ppg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);

   ppg_pkg::ppg_stage_type  stage_ff, stage_in;
   logic                    stage_valid_ff, stage_valid_in;
   ppg_pkg::ppg_result_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    enable_ff, enable_in;
   ppg_pkg::ppg_result_type result;
   logic                    rsp_advance;
   logic                    stage_advance;
   logic [ppg_pkg::COORD_BITS-1:0]      req_y;
   logic [ppg_pkg::RECIP_PROD_BITS-1:0] third_prod;

   ppg_plasma u_plasma (
      .stage  (stage_ff),
      .result (result)
   );

   assign rsp_advance   = !rsp_valid_ff || rsp_tready;
   assign stage_advance = !stage_valid_ff || rsp_advance;
   assign req_tready    = stage_advance;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_ff;

   assign req_y      = req_tdata[ppg_pkg::COORD_BITS +: ppg_pkg::COORD_BITS];
   assign third_prod = ppg_pkg::RECIP_PROD_BITS'(req_y)
                     * ppg_pkg::RECIP_PROD_BITS'(ppg_pkg::RECIP_THIRD);

   always_comb begin
      enable_in      = csr_wr_en ? csr_wr_data : enable_ff;
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (stage_advance) begin
         stage_valid_in = req_tvalid && enable_ff;
         if (req_tvalid) begin
            stage_in.mode    = req_tuser;
            stage_in.pixel_x = req_tdata[0 +: ppg_pkg::COORD_BITS];
            stage_in.pixel_y = req_y;
            stage_in.phase   = req_tdata[2 * ppg_pkg::COORD_BITS +: 8];
            stage_in.y_third = third_prod[ppg_pkg::RECIP_SHIFT +: ppg_pkg::THIRD_BITS];
         end
      end
      if (rsp_advance) begin
         rsp_valid_in = stage_valid_ff;
         if (stage_valid_ff) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         enable_ff      <= 1'b1;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         enable_ff      <= enable_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   a_index_below_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.palette_index != 8'hFF))
      else $error("palette index out of range");

   a_red_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.color[23:16] == 8'h00))
      else $error("red channel not zero");

   a_disabled_drop: assert property (@(posedge clock) disable iff (reset)
      (!stage_valid_ff && !enable_ff) |=> !stage_valid_ff)
      else $error("beat entered while disabled");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_advance) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("stalled stage changed");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      (rsp_advance && !stage_valid_ff) |=> !rsp_valid_ff)
      else $error("result beat without source");

endmodule

>>> src/ppg_plasma.sv
// Plasma value, modulo-255 reduction and palette lookup for one registered pixel.
module ppg_plasma (
   input  ppg_pkg::ppg_stage_type  stage,
   output ppg_pkg::ppg_result_type result
);

   logic [7:0]                         t1_c;
   logic [7:0]                         t2_c;
   logic [7:0]                         idx_a;
   logic [ppg_pkg::COORD_BITS:0]       sum_xy;
   logic [ppg_pkg::PROD_A_BITS-1:0]    prod_a;
   logic [7:0]                         idx_b;
   logic [ppg_pkg::HALF_BITS-1:0]      half_x;
   logic [ppg_pkg::HALF_BITS-1:0]      half_y;
   logic [7:0]                         idx_c;
   logic [ppg_pkg::TERM_BITS-1:0]      term;
   logic [ppg_pkg::PROD_B_BITS-1:0]    prod_b;
   logic [7:0]                         idx_d;
   logic [9:0]                         r_small;
   logic [9:0]                         r_big;
   logic [9:0]                         r_sum;
   logic [8:0]                         folded;
   logic [7:0]                         index;

   always_comb begin
      t1_c = ppg_pkg::T1_ROM[stage.phase];
      t2_c = ppg_pkg::T2_ROM[stage.phase];

      idx_a   = stage.phase + 8'({stage.pixel_x, 1'b0});
      sum_xy  = {1'b0, stage.pixel_x} + {1'b0, stage.pixel_y};
      prod_a  = ppg_pkg::PROD_A_BITS'(sum_xy) * ppg_pkg::PROD_A_BITS'(t1_c);
      idx_b   = prod_a[7 +: 8];
      r_small = 10'(stage.phase) + 10'(ppg_pkg::T1_ROM[idx_a]) + 10'(ppg_pkg::T1_ROM[idx_b]);

      half_x = stage.pixel_x[ppg_pkg::COORD_BITS-1:1];
      half_y = stage.pixel_y[ppg_pkg::COORD_BITS-1:1];
      idx_c  = 8'(ppg_pkg::TERM_BITS'(half_x) + ppg_pkg::TERM_BITS'(half_y));
      term   = ppg_pkg::TERM_BITS'(stage.y_third) + ppg_pkg::TERM_BITS'(t2_c);
      prod_b = ppg_pkg::PROD_B_BITS'(half_y) * ppg_pkg::PROD_B_BITS'(term);
      idx_d  = prod_b[8 +: 8];
      r_big  = {1'b0, stage.phase, 1'b0} + 10'(ppg_pkg::T2_ROM[idx_c])
             + 10'(ppg_pkg::T1_ROM[idx_d]);

      r_sum  = stage.mode ? r_big : r_small;
      folded = {1'b0, r_sum[7:0]} + {7'd0, r_sum[9:8]};
      index  = (folded >= ppg_pkg::MOD_BASE) ? 8'(folded - ppg_pkg::MOD_BASE) : folded[7:0];

      result.palette_index = index;
      result.color         = ppg_pkg::PAL_ROM[index];
   end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the plasma pixel generator: stream stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module tb_top;

   localparam logic MODE_SMALL = 1'b0;
   localparam logic MODE_BIG   = 1'b1;
   localparam logic ENABLE_OFF = 1'b0;
   localparam logic ENABLE_ON  = 1'b1;

   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 200000;

   localparam longint FIX_ONE     = 64'sd1073741824;
   localparam longint FIX_PI      = 64'sd3373259426;
   localparam longint FIX_HALF_PI = 64'sd1686629713;

   typedef struct packed {
      logic                           mode;
      logic [ppg_pkg::COORD_BITS-1:0] x;
      logic [ppg_pkg::COORD_BITS-1:0] y;
      logic [7:0]                     phase;
   } pixel_type;

   typedef struct packed {
      logic       mode;
      logic [8:0] x;
      logic [8:0] y;
      logic [7:0] phase;
      logic       idx_known;
      logic [7:0] idx;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{MODE_SMALL, 9'd0,   9'd0,   8'd0,   1'b1, 8'd254},
      '{MODE_BIG,   9'd0,   9'd0,   8'd0,   1'b1, 8'd254},
      '{MODE_SMALL, 9'd0,   9'd0,   8'd64,  1'b1, 8'd190},
      '{MODE_BIG,   9'd0,   9'd0,   8'd64,  1'b1, 8'd127},
      '{MODE_SMALL, 9'd0,   9'd0,   8'd128, 1'b1, 8'd127},
      '{MODE_BIG,   9'd0,   9'd0,   8'd128, 1'b1, 8'd0},
      '{MODE_SMALL, 9'd0,   9'd0,   8'd192, 1'b1, 8'd63},
      '{MODE_BIG,   9'd0,   9'd0,   8'd192, 1'b1, 8'd128},
      '{MODE_SMALL, 9'd511, 9'd511, 8'd255, 1'b0, 8'd0},
      '{MODE_BIG,   9'd511, 9'd511, 8'd255, 1'b0, 8'd0},
      '{MODE_SMALL, 9'd511, 9'd0,   8'd0,   1'b0, 8'd0},
      '{MODE_SMALL, 9'd0,   9'd511, 8'd0,   1'b0, 8'd0},
      '{MODE_BIG,   9'd511, 9'd0,   8'd17,  1'b0, 8'd0},
      '{MODE_BIG,   9'd0,   9'd511, 8'd200, 1'b0, 8'd0},
      '{MODE_SMALL, 9'd256, 9'd1,   8'd255, 1'b0, 8'd0},
      '{MODE_BIG,   9'd1,   9'd256, 8'd1,   1'b0, 8'd0},
      '{MODE_SMALL, 9'd170, 9'd85,  8'hAA,  1'b0, 8'd0},
      '{MODE_BIG,   9'd341, 9'd170, 8'h55,  1'b0, 8'd0},
      '{MODE_SMALL, 9'd0,   9'd0,   8'd255, 1'b0, 8'd0},
      '{MODE_BIG,   9'd511, 9'd511, 8'd0,   1'b0, 8'd0},
      '{MODE_SMALL, 9'd511, 9'd511, 8'd127, 1'b0, 8'd0}
   };

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [ppg_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [ppg_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              csr_wr_en;
   logic                              csr_wr_data;

   logic [7:0]  t1_tab   [256];
   logic [7:0]  t2_tab   [256];
   logic [31:0] argb_tab [256];

   ppg_pkg::ppg_result_type pending_pixels [$];

   logic enable_shadow;
   logic hold_off_pending;
   int   burst_left;
   int   cycle_count;
   int   rx_cycle;
   int   mismatch_count;
   int   pixels_checked;
   int   small_sent;
   int   big_sent;
   int   muted_sent;
   int   enable_writes;
   int   hold_offs;

   plasma_pixel_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // sine of a nonnegative Q30 angle, truncated Taylor series
   function automatic longint fix_sin(input longint angle);
      longint a;
      longint sq;
      longint term;
      longint acc;
      a = angle;
      if (a > FIX_PI) a = FIX_PI;
      if (a > FIX_HALF_PI) a = FIX_PI - a;
      if (a == FIX_HALF_PI) return FIX_ONE;
      sq   = (a * a) >> 30;
      term = a;
      acc  = a;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * sq) >> 30) / longint'(2 * k * (2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      if (acc > FIX_ONE) acc = FIX_ONE;
      return acc;
   endfunction

   // sin(pi * k / 128), signed Q30
   function automatic longint step_sin(input int k);
      int     quad;
      int     rem;
      longint v;
      quad = (k >> 6) & 3;
      rem  = k & 63;
      if (rem == 0) begin
         v = (quad == 1) ? FIX_ONE : (quad == 3) ? -FIX_ONE : 64'sd0;
      end else begin
         v = fix_sin((FIX_PI * longint'((quad % 2 == 1) ? 64 - rem : rem)) / 128);
         if (quad >= 2) v = -v;
      end
      return v;
   endfunction

   // sin(pi * s / den) for signed Q30 s
   function automatic longint scaled_sin(input longint s, input int den);
      longint mag;
      longint v;
      mag = (s < 0) ? -s : s;
      v   = fix_sin(((FIX_PI * mag) >> 30) / longint'(den));
      return (s < 0) ? -v : v;
   endfunction

   function automatic ppg_pkg::ppg_result_type plasma_pixel(input pixel_type px);
      int unsigned x;
      int unsigned y;
      int unsigned c;
      int unsigned r;
      ppg_pkg::ppg_result_type res;
      x = px.x;
      y = px.y;
      c = px.phase;
      if (px.mode == MODE_SMALL) begin
         r = c + t1_tab[8'(c + 2 * x)] + t1_tab[8'(((x + y) * t1_tab[c]) / 128)];
      end else begin
         r = 2 * c + t2_tab[8'(x / 2 + y / 2)]
             + t1_tab[8'(((y / 2) * (y / 3 + t2_tab[c])) / 256)];
      end
      r = r % 255;
      res.palette_index = 8'(r);
      res.color         = argb_tab[r];
      return res;
   endfunction

   task automatic send_pixel(input pixel_type px, input ppg_pkg::ppg_result_type want);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tuser  = px.mode;
      req_tdata  = {px.phase, px.y, px.x};
      do @(posedge clock); while (!req_tready);
      if (enable_shadow) begin
         pending_pixels.push_back(want);
         if (px.mode == MODE_SMALL) small_sent++;
         else big_sent++;
      end else begin
         muted_sent++;
      end
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      pixel_type px;
      repeat (count) begin
         px.mode  = 1'($urandom_range(0, 1));
         px.x     = ppg_pkg::COORD_BITS'($urandom);
         px.y     = ppg_pkg::COORD_BITS'($urandom);
         px.phase = 8'($urandom);
         if ($urandom_range(0, 7) == 0) px.x = $urandom_range(0, 1) ? '1 : '0;
         if ($urandom_range(0, 7) == 0) px.y = $urandom_range(0, 1) ? '1 : '0;
         if ($urandom_range(0, 7) == 0) px.phase = $urandom_range(0, 1) ? '1 : '0;
         send_pixel(px, plasma_pixel(px));
      end
   endtask

   task automatic set_enable(input logic value);
      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      enable_shadow = value;
      enable_writes++;
   endtask

   // receiver stall patterns, plus a long hold-off on request
   always begin
      @(negedge clock);
      rx_cycle++;
      if (hold_off_pending) begin
         rsp_tready = 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
         hold_off_pending = 1'b0;
         hold_offs++;
      end else begin
         case (rx_cycle[9:7])
            3'd0, 3'd4: rsp_tready = 1'b1;
            3'd1:       rsp_tready = ($urandom_range(0, 3) != 0);
            3'd2:       rsp_tready = ($urandom_range(0, 3) == 0);
            3'd3:       rsp_tready = rx_cycle[0];
            3'd5:       rsp_tready = 1'($urandom_range(0, 1));
            3'd6:       rsp_tready = rx_cycle[1];
            default:    rsp_tready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      ppg_pkg::ppg_result_type got;
      ppg_pkg::ppg_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            $error("result beat with nothing pending: palette_index %0d color %08h",
                   got.palette_index, got.color);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.palette_index !== want.palette_index) begin
               $error("palette_index mismatch: expected %0d, actual %0d",
                      want.palette_index, got.palette_index);
               mismatch_count++;
            end
            if (got.color !== want.color) begin
               $error("color mismatch: expected %08h, actual %08h", want.color, got.color);
               mismatch_count++;
            end
            pixels_checked++;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("plasma_pixel_generator test failed");
      $finish;
   end

   initial begin
      longint s;
      longint mag;
      longint u;
      pixel_type px;
      ppg_pkg::ppg_result_type want;

      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      rsp_tready       = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      enable_shadow    = ENABLE_ON;
      hold_off_pending = 1'b0;
      burst_left       = 0;
      rx_cycle         = 0;
      mismatch_count   = 0;
      pixels_checked   = 0;
      small_sent       = 0;
      big_sent         = 0;
      muted_sent       = 0;
      enable_writes    = 0;
      hold_offs        = 0;

      for (int i = 0; i < 256; i++) begin
         s   = step_sin(i);
         mag = (s < 0) ? -s : s;
         u   = (FIX_ONE + s) >> 1;
         t1_tab[i]   = 8'((127 * FIX_ONE + 127 * ((mag * mag) >> 30)) >> 30);
         t2_tab[i]   = 8'((127 * FIX_ONE + 127 * scaled_sin(s, 1)) >> 30);
         argb_tab[i] = {8'((191 * FIX_ONE + 64 * scaled_sin(s, 2)) >> 30), 8'h00,
                        8'((200 * ((u * u) >> 30)) >> 30), 8'((200 * u) >> 30)};
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_table[i]) begin
         px.mode  = directed_table[i].mode;
         px.x     = directed_table[i].x;
         px.y     = directed_table[i].y;
         px.phase = directed_table[i].phase;
         want     = plasma_pixel(px);
         if (directed_table[i].idx_known) want.palette_index = directed_table[i].idx;
         send_pixel(px, want);
      end

      set_enable(ENABLE_OFF);
      send_random(30);
      set_enable(ENABLE_ON);
      hold_off_pending = 1'b1;
      send_random(700);
      set_enable(ENABLE_OFF);
      send_random(30);
      set_enable(ENABLE_ON);
      hold_off_pending = 1'b1;
      send_random(700);

      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d small-mode and %0d big-mode pixels, %0d results checked",
               small_sent, big_sent, pixels_checked);
      $display("%0d pixels sent while muted, %0d enable writes, %0d receiver hold-offs",
               muted_sent, enable_writes, hold_offs);
      if (mismatch_count == 0) begin
         $display("plasma_pixel_generator test passed");
      end else begin
         $display("plasma_pixel_generator test failed");
      end
      $finish;
   end

endmodule
